>>> hw/rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int OUT_SPAN       = 1024;
  localparam int FIRST_BLOCK    = 2;
  localparam int WORD_W         = 64;
  localparam int POS_W          = 6;
  localparam int DISK_W         = 11;
  localparam int BLK_W          = 10;
  localparam int STAT_W         = 2;

  localparam logic [DISK_W-1:0] DISK_SIZE_RST = DISK_W'(1024);

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_OUT          = 2'd1,
    ST_INVALID      = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } scan_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/bba_if.sv
`default_nettype none

interface bba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [bba_pkg::BLK_W-1:0] block_number;

  modport source (output valid, output kind, output block_number, input ready);
  modport sink   (input valid, input kind, input block_number, output ready);
endinterface

interface bba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::BLK_W-1:0]  allocated_block;
  logic [bba_pkg::STAT_W-1:0] status;

  modport source (output valid, output allocated_block, output status, input ready);
  modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bba_ram.sv
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/bba_scan.sv
`default_nettype none

module bba_scan #(
  parameter int AW = 4
) (
  input  logic [bba_pkg::WORD_W-1:0] word,
  input  logic [AW-1:0]              word_idx,
  input  logic [AW-1:0]              last_word,
  input  logic [bba_pkg::POS_W-1:0]  top_pos,
  output bba_pkg::scan_res_t         res
);

  import bba_pkg::*;

  logic [WORD_W-1:0] free_bits;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      free_bits[i] = !word[i]
                     && !((word_idx == '0) && (i < FIRST_BLOCK))
                     && !((word_idx == last_word) && (POS_W'(i) > top_pos));
    end
  end

  always_comb begin
    res.found = 1'b0;
    res.pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        res.found = 1'b1;
        res.pos   = POS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_block_allocator.sv
`default_nettype none

// channel   dir  payload                          handshake
// req       in   kind, block_number               valid/ready
// rsp       out  allocated_block, status          valid/ready
// cfg       in   cfg_wr_data (disk_size)          cfg_wr_en, no back-pressure
//
// Allocate scans one 64-bit map word per cycle for the lowest free bit; the map
// write is skipped when no block is free.
// Free steps through read, check, write and respond, skipping the write if already free;
// rejects go straight to respond. After rst the map is cleared one word per cycle, all
// map words (at least 2), before the first transaction. A stalled rsp holds the block only
// once the next result waits to load behind the output register.

module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  bba_req_if.sink                    req,
  bba_rsp_if.source                  rsp,
  input  logic                       cfg_wr_en,
  input  logic [bba_pkg::DISK_W-1:0] cfg_wr_data
);

  import bba_pkg::*;

  localparam int USED_BLOCKS   = (NUM_BLOCKS < OUT_SPAN) ? NUM_BLOCKS : OUT_SPAN;
  localparam int MAP_WORDS_RAW = (USED_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int MAP_WORDS     = (MAP_WORDS_RAW < 2) ? 2 : MAP_WORDS_RAW;
  localparam int AW            = $clog2(MAP_WORDS);
  localparam logic [DISK_W-1:0] LIM_MAX = DISK_W'(USED_BLOCKS);
  localparam logic [AW-1:0]     LAST_ROW = AW'(MAP_WORDS - 1);

  state_t state, state_next;

  logic [DISK_W-1:0] disk_size;
  logic [DISK_W-1:0] lim;
  logic [DISK_W-1:0] lim_m1;
  logic [AW-1:0]     last_word;
  logic [POS_W-1:0]  top_pos;

  kind_t             kind_q;
  logic [BLK_W-1:0]  bno_q;
  logic [AW-1:0]     rd_ptr;
  logic              issuing;
  logic              chk_vld;
  logic [AW-1:0]     chk_ptr;
  logic [AW-1:0]     clr_ptr;
  logic [AW-1:0]     wr_addr_q;
  logic [WORD_W-1:0] wr_data_q;
  logic [BLK_W-1:0]  res_block;
  status_t           res_status;

  logic              rsp_valid;
  logic [BLK_W-1:0]  rsp_block;
  status_t           rsp_status;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  scan_res_t         scan;

  logic              accept;
  logic              req_free;
  logic              bno_bad;
  logic              found;
  logic              scan_end;
  logic              bit_used;
  logic              rsp_load;

  assign lim       = (disk_size > LIM_MAX) ? LIM_MAX : disk_size;
  assign lim_m1    = lim - DISK_W'(1);
  assign last_word = lim_m1[AW+POS_W-1:POS_W];
  assign top_pos   = lim_m1[POS_W-1:0];

  assign accept   = req.valid && req.ready;
  assign req_free = (kind_t'(req.kind) == KIND_FREE);
  assign bno_bad  = (req.block_number < BLK_W'(FIRST_BLOCK))
                    || ({1'b0, req.block_number} >= lim);
  assign found    = chk_vld && scan.found;
  assign scan_end = chk_vld && !scan.found && (chk_ptr == last_word);
  assign bit_used = ram_rdata[bno_q[POS_W-1:0]];
  assign rsp_load = (state == S_RESP) && (!rsp_valid || rsp.ready);

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bba_scan #(
    .AW (AW)
  ) u_scan (
    .word      (ram_rdata),
    .word_idx  (chk_ptr),
    .last_word (last_word),
    .top_pos   (top_pos),
    .res       (scan)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_ptr == LAST_ROW) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_free) begin
            state_next = bno_bad ? S_RESP : S_FREE_RD;
          end else begin
            state_next = (lim > DISK_W'(FIRST_BLOCK)) ? S_SCAN : S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          state_next = S_WRITE;
        end else if (scan_end) begin
          state_next = S_RESP;
        end
      end
      S_FREE_RD:  state_next = S_FREE_CHK;
      S_FREE_CHK: state_next = bit_used ? S_WRITE : S_RESP;
      S_WRITE:    state_next = S_RESP;
      S_RESP: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = wr_data_q;
    ram_raddr = rd_ptr;
    req.ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr;
        ram_wdata = '0;
      end
      S_IDLE:    req.ready = 1'b1;
      S_FREE_RD: ram_raddr = bno_q[AW+POS_W-1:POS_W];
      S_WRITE:   ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      disk_size <= DISK_SIZE_RST;
      clr_ptr   <= '0;
      issuing   <= 1'b0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        disk_size <= cfg_wr_data;
      end
      if (state == S_CLEAR) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (accept) begin
        issuing <= !req_free;
        chk_vld <= 1'b0;
      end else if (state == S_SCAN) begin
        issuing <= issuing && (rd_ptr != last_word);
        chk_vld <= issuing;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind_q     <= kind_t'(req.kind);
        bno_q      <= req.block_number;
        rd_ptr     <= '0;
        res_block  <= '0;
        res_status <= req_free ? ST_INVALID : ST_OUT;
      end
      S_SCAN: begin
        if (issuing) begin
          rd_ptr <= rd_ptr + AW'(1);
        end
        chk_ptr <= rd_ptr;
        if (found) begin
          wr_addr_q  <= chk_ptr;
          wr_data_q  <= ram_rdata | (WORD_W'(1) << scan.pos);
          res_block  <= BLK_W'({chk_ptr, scan.pos});
          res_status <= ST_OK;
        end
      end
      S_FREE_CHK: begin
        wr_addr_q  <= bno_q[AW+POS_W-1:POS_W];
        wr_data_q  <= ram_rdata & ~(WORD_W'(1) << bno_q[POS_W-1:0]);
        res_status <= bit_used ? ST_OK : ST_ALREADY_FREE;
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      rsp_block  <= res_block;
      rsp_status <= res_status;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.allocated_block = rsp_block;
  assign rsp.status          = rsp_status;

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> rsp.allocated_block == '0)
    else $error("nonzero block with failing status");

  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && found |-> {1'b0, BLK_W'({chk_ptr, scan.pos})} < lim)
    else $error("granted block outside disk");

  a_write_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) && (kind_q == KIND_ALLOC) |-> wr_data_q[res_block[POS_W-1:0]])
    else $error("allocated bit not set in write word");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("map written while idle");

  a_resp_after_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (state == S_RESP))
    else $error("write not followed by response");

endmodule

`default_nettype wire
